FILE: rtl/core/assert_macros.svh
// assertion macros shared by the icmp checker rtl
// used by icmp_queue and icmp_back, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled while in reset
`define ICMP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ICMP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ICMP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/icmp_pkg.sv
// types and constants for the icmp echo reply checker
// no dependencies
`default_nettype none

package icmp_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_CSUM_BAD   = 3'd3,
    ST_NOT_REPLY  = 3'd4,
    ST_FOREIGN_ID = 3'd5
  } status_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ICMP_MIN_BYTES = 16'd8;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;
  localparam logic [15:0] TRIP_MIN_RESET = 16'hffff;

  // per-datagram summary handed from front to back
  typedef struct packed {
    logic [15:0] len;
    logic [5:0]  hdr;
    logic [15:0] total;
    logic [15:0] sum;
    logic [7:0]  rtype;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] now;
  } rec_t;

endpackage

`default_nettype wire

FILE: rtl/core/icmp_front.sv
// byte front end: offset tracking, checksum accumulation, field capture
// depends on icmp_pkg
`default_nettype none

module icmp_front import icmp_pkg::*; #(
  parameter int unsigned MAX_DATAGRAM = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        q_full,
  output logic             push,
  output rec_t             rec
);

  localparam int unsigned OFF_W = $clog2(MAX_DATAGRAM + 1);

  logic [OFF_W-1:0] offset;
  logic [5:0]       hdr;
  logic [15:0]      total;
  logic [15:0]      sum;
  logic [7:0]       rtype;
  logic [15:0]      ident;
  logic [15:0]      seq;
  logic [31:0]      stamp;

  logic [OFF_W-1:0] offset_next;
  logic [5:0]       hdr_next;
  logic [15:0]      total_next;
  logic [15:0]      sum_next;
  logic [7:0]       rtype_next;
  logic [15:0]      ident_next;
  logic [15:0]      seq_next;
  logic [31:0]      stamp_next;

  logic [7:0]  b;
  logic [15:0] o16;
  logic [15:0] r;
  logic [15:0] word;
  logic [16:0] s17;
  logic        accept;

  assign b        = s_tdata[7:0];
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;
  assign o16      = 16'(offset);

  always_comb begin
    offset_next = offset;
    hdr_next    = hdr;
    total_next  = total;
    sum_next    = sum;
    rtype_next  = rtype;
    ident_next  = ident;
    seq_next    = seq;
    stamp_next  = stamp;
    word        = offset[0] ? {b, 8'h00} : {8'h00, b};
    s17         = {1'b0, sum} + {1'b0, word};
    r           = 16'd0;
    if (offset < OFF_W'(MAX_DATAGRAM)) begin
      offset_next = offset + OFF_W'(1);
      if (o16 == 16'd0) begin
        hdr_next = {b[3:0], 2'b00};
      end else if (o16 == 16'd2) begin
        total_next = {b, total[7:0]};
      end else if (o16 == 16'd3) begin
        total_next = {total[15:8], b};
      end
      if (o16 >= 16'(hdr_next)) begin
        if (o16 < 16'd4 || o16 < total) begin
          sum_next = s17[16] ? s17[15:0] + 16'd1 : s17[15:0];
        end
        r = o16 - 16'(hdr_next);
        case (r)
          16'd0:   rtype_next = b;
          16'd4:   ident_next[7:0] = b;
          16'd5:   ident_next[15:8] = b;
          16'd6:   seq_next[7:0] = b;
          16'd7:   seq_next[15:8] = b;
          16'd8:   stamp_next[7:0] = b;
          16'd9:   stamp_next[15:8] = b;
          16'd10:  stamp_next[23:16] = b;
          16'd11:  stamp_next[31:24] = b;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rec.len   = 16'(offset_next);
    rec.hdr   = hdr_next;
    rec.total = total_next;
    rec.sum   = sum_next;
    rec.rtype = rtype_next;
    rec.ident = ident_next;
    rec.seq   = seq_next;
    rec.stamp = stamp_next;
    rec.now   = s_tdata[39:8];
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      offset <= '0;
      hdr    <= '0;
      total  <= '0;
      sum    <= '0;
      rtype  <= '0;
      ident  <= '0;
      seq    <= '0;
      stamp  <= '0;
    end else if (accept) begin
      offset <= offset_next;
      hdr    <= hdr_next;
      total  <= total_next;
      sum    <= sum_next;
      rtype  <= rtype_next;
      ident  <= ident_next;
      seq    <= seq_next;
      stamp  <= stamp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/icmp_queue.sv
// short queue of datagram summaries between front and back
// depends on icmp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module icmp_queue import icmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t wr_rec,
  output logic      full,
  output logic      q_valid,
  input  wire logic pop,
  output rec_t      rd_rec
);

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_rec  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  `ICMP_ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop, "queue written while full")
  `ICMP_ASSERT_IMP(a_no_underflow, clk, rst, pop, q_valid, "queue read while empty")

endmodule

`default_nettype wire

FILE: rtl/core/icmp_back.sv
// back end: status decision, trip time, statistics and output register
// depends on icmp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module icmp_back import icmp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [15:0]  own_identifier,
  input  wire logic         q_valid,
  input  wire rec_t         q_rec,
  output logic              pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [199:0]      m_tdata
);

  // stage a: decided item
  logic        a_valid;
  status_t     a_status;
  logic [15:0] a_seq;
  logic [31:0] a_trip;
  logic [15:0] a_payload;

  // output stage
  status_t     m_status;
  logic [15:0] m_seq;
  logic [31:0] m_trip;
  logic [15:0] m_payload;

  logic [31:0] rcv_count;
  logic [31:0] trip_min;
  logic [31:0] trip_max;
  logic [31:0] trip_sum;

  status_t     status_next;
  logic [31:0] trip_next;
  logic [15:0] payload_next;
  logic        b_load;
  logic        a_ok;

  assign b_load = a_valid && (!m_tvalid || m_tready);
  assign pop    = q_valid && (!a_valid || b_load);
  assign a_ok   = (a_status == ST_OK);

  always_comb begin
    if ({1'b0, q_rec.len} < 17'(q_rec.hdr) + 17'(ICMP_MIN_BYTES)) begin
      status_next = ST_TOO_SHORT;
    end else if (q_rec.len < q_rec.total) begin
      status_next = ST_TRUNCATED;
    end else if (q_rec.sum != SUM_GOOD) begin
      status_next = ST_CSUM_BAD;
    end else if (q_rec.rtype != 8'd0) begin
      status_next = ST_NOT_REPLY;
    end else if (q_rec.ident != own_identifier) begin
      status_next = ST_FOREIGN_ID;
    end else begin
      status_next = ST_OK;
    end
    if (status_next == ST_OK) begin
      trip_next    = q_rec.now - q_rec.stamp;
      payload_next = q_rec.total - 16'(q_rec.hdr) - ICMP_MIN_BYTES;
    end else begin
      trip_next    = '0;
      payload_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_status  <= status_next;
      a_seq     <= q_rec.seq;
      a_trip    <= trip_next;
      a_payload <= payload_next;
    end
    if (b_load) begin
      m_status  <= a_status;
      m_seq     <= a_seq;
      m_trip    <= a_trip;
      m_payload <= a_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      m_tvalid  <= 1'b0;
      rcv_count <= '0;
      trip_min  <= 32'(TRIP_MIN_RESET);
      trip_max  <= '0;
      trip_sum  <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (b_load && a_ok) begin
        rcv_count <= rcv_count + 32'd1;
        trip_sum  <= trip_sum + a_trip;
        if (a_trip < trip_min) begin
          trip_min <= a_trip;
        end
        if (a_trip > trip_max) begin
          trip_max <= a_trip;
        end
      end
    end
  end

  // status, seq, trip, payload, count, min, max, total, pad
  assign m_tdata = {5'd0, trip_sum, trip_max, trip_min, rcv_count,
                    m_payload, m_trip, m_seq, 3'(m_status)};

  `ICMP_ASSERT_NXT(a_count_step, clk, rst, b_load && a_ok,
    rcv_count == $past(rcv_count) + 32'd1, "count not stepped on good reply")
  `ICMP_ASSERT_IMP(a_zero_on_fail, clk, rst, m_tvalid && m_status != ST_OK,
    m_trip == 32'd0 && m_payload == 16'd0, "trip or payload set on failed reply")
  `ICMP_ASSERT_IMP(a_min_le_max, clk, rst, rcv_count != 32'd0,
    trip_min <= trip_max, "minimum trip above maximum")

endmodule

`default_nettype wire

FILE: rtl/core/icmp_echo_reply_checker.sv
// icmp echo reply checker, top level
// depends on icmp_pkg, icmp_front, icmp_queue, icmp_back
//
// usage:
//   s_* carries the received ipv4 datagram one byte per item, s_tlast on the
//   final byte; s_tdata holds the byte and the current millisecond tick.
//   m_* gives one result item per datagram: status, echo sequence, trip time,
//   payload length and the running reply statistics.
//   cfg_we/cfg_wdata set the identifier that good replies must carry; write
//   it only while no datagram is in flight.
// throughput: one byte per cycle while the queue is not full (s_tready high);
//   the checksum add in the front end is combinational.
// result path: after the edge that takes the last byte, the summary passes the
//   summary queue, decision stage and output register before m_tvalid rises.
// reset: per-datagram state, queue and output clear; statistics return to
//   count 0, minimum 65535, maximum 0, total 0; identifier becomes 0.
// stall: while m_tready is low the result holds; bytes keep flowing until
//   the queue holds four finished datagrams behind the two held in the back
//   end, then s_tready drops.
`default_nettype none

module icmp_echo_reply_checker import icmp_pkg::*; #(
  parameter int unsigned MAX_DATAGRAM = 65535
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // data_byte, now_ms
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [199:0]      m_tdata,   // status, sequence_res, trip_ms, payload_length,
                                       // received_count, min_trip, max_trip, total_trip
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata
);

  logic [15:0] own_identifier;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  rec_t        wr_rec;
  rec_t        rd_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_identifier <= '0;
    end else if (cfg_we) begin
      own_identifier <= cfg_wdata;
    end
  end

  icmp_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .rec      (wr_rec)
  );

  icmp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_rec  (wr_rec),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (pop),
    .rd_rec  (rd_rec)
  );

  icmp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .own_identifier (own_identifier),
    .q_valid        (q_valid),
    .q_rec          (rd_rec),
    .pop            (pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule

`default_nettype wire
